@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros used by the port-level checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, masked during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// condition that holds in the cycle after reset was asserted
`define ASSERT_AFTER_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) $past(rst) |-> (cons)) \
    else $error("post-reset check failed");

`endif

@@ rtl/bped_pkg.sv @@
// ----------------------------------------------------------------------------
// bped_pkg
// Types and constants shared by the button press event detector.
// ----------------------------------------------------------------------------
package bped_pkg;

  // widths fixed by the register map and the item fields
  localparam int MaxButtonsDefault = 8;
  localparam int LevelWidth        = 8;
  localparam int CountWidth        = 4;
  localparam int IndexWidth        = 3;
  localparam int CfgIndexWidth     = 3;
  localparam int CfgDataWidth      = 8;

  // queue depths (powers of two)
  localparam int JobDepth = 2;
  localparam int EvqDepth = 16;

  typedef enum logic [2:0] {
    EV_DOWN  = 3'd0,
    EV_UP    = 3'd1,
    EV_SHORT = 3'd2,
    EV_LONG  = 3'd3,
    EV_KEEP  = 3'd4
  } event_kind_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_BUTTON_COUNT  = 3'd0,
    CFG_ACTIVE_LEVELS = 3'd1,
    CFG_TICK_INTERVAL = 3'd2,
    CFG_SHORT_MIN     = 3'd3,
    CFG_LONG_MIN      = 3'd4,
    CFG_KEEP_MIN      = 3'd5,
    CFG_KEEP_MAX      = 3'd6,
    CFG_KEEP_PRESCALE = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [CountWidth-1:0] button_count;
    logic [7:0]            active_levels;
    logic [7:0]            tick_interval;
    logic [7:0]            short_min;
    logic [7:0]            long_min;
    logic [7:0]            keep_min;
    logic [7:0]            keep_max;
    logic [7:0]            keep_prescale;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    button_count:  4'd0,
    active_levels: 8'd0,
    tick_interval: 8'd5,
    short_min:     8'd3,
    long_min:      8'd50,
    keep_min:      8'd100,
    keep_max:      8'd200,
    keep_prescale: 8'd10
  };

  typedef struct packed {
    logic [IndexWidth-1:0] button_index;
    event_kind_t           kind;
    logic                  last;
  } event_t;

  typedef struct packed {
    logic   valid;
    event_t ev;
  } event_push_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_EVAL,
    SC_SECOND,
    SC_FLUSH
  } scan_state_t;

endpackage

@@ rtl/bped_front.sv @@
// ----------------------------------------------------------------------------
// bped_front
// Accepts ticks, runs the tick divider and queues the levels of each tick
// that starts a scan.
// ----------------------------------------------------------------------------
module bped_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [bped_pkg::LevelWidth-1:0] button_levels,
  input  logic [7:0]                     tick_interval,
  output logic                           job_valid,
  output logic [bped_pkg::LevelWidth-1:0] job_levels,
  input  logic                           job_pop
);
  import bped_pkg::*;

  localparam int PtrW = (JobDepth > 1) ? $clog2(JobDepth) : 1;
  localparam int CntW = $clog2(JobDepth + 1);

  logic [7:0]            divider;
  logic [7:0]            divider_next;
  logic                  scan_due;
  logic                  accept;
  logic                  wr_en;
  logic                  rd_en;
  logic [PtrW-1:0]       wr_ptr;
  logic [PtrW-1:0]       rd_ptr;
  logic [CntW-1:0]       count;
  logic [LevelWidth-1:0] mem [JobDepth];

  // divider step and scan decision
  assign divider_next = divider + 8'd1;
  assign scan_due     = (divider_next >= tick_interval);
  assign accept       = push && !full;
  assign wr_en        = accept && scan_due;
  assign rd_en        = job_pop && job_valid;

  assign full       = (count == CntW'(JobDepth));
  assign job_valid  = (count != '0);
  assign job_levels = mem[rd_ptr];

  // tick divider
  always_ff @(posedge clk) begin
    if (rst) begin
      divider <= '0;
    end else if (accept) begin
      divider <= scan_due ? 8'd0 : divider_next;
    end
  end

  // scan job queue
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= button_levels;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CntW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

@@ rtl/bped_scan.sv @@
// ----------------------------------------------------------------------------
// bped_scan
// Walks the buttons of one scan job, an EVAL and a SECOND state per button,
// updates the press counters and the shared keep prescaler, and issues
// events. The newest event waits in a holding register so the final one
// of a scan can be marked when the walk ends.
// ----------------------------------------------------------------------------
module bped_scan #(
  parameter int MAX_BUTTONS = bped_pkg::MaxButtonsDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bped_pkg::cfg_t                  cfg,
  input  logic                            job_valid,
  input  logic [bped_pkg::LevelWidth-1:0] job_levels,
  output logic                            job_pop,
  output bped_pkg::event_push_t           evq_push,
  input  logic                            evq_full
);
  import bped_pkg::*;

  localparam int ScanDepth = (MAX_BUTTONS < LevelWidth) ? MAX_BUTTONS : LevelWidth;
  localparam int SelW      = (ScanDepth > 1) ? $clog2(ScanDepth) : 1;

  scan_state_t           state;
  scan_state_t           state_next;
  logic [CountWidth-1:0] idx;
  logic [CountWidth-1:0] idx_inc;
  logic [CountWidth-1:0] n_btn;
  logic [CountWidth-1:0] n_lim;
  logic [LevelWidth-1:0] levels;
  logic [7:0]            counts [ScanDepth];
  logic [7:0]            prescaler;
  event_t                pend;
  logic                  pend_valid;
  logic                  evb_valid;
  event_kind_t           evb_kind;

  logic [SelW-1:0]       sel;
  logic [IndexWidth-1:0] bit_sel;
  logic [7:0]            c;
  logic                  pressed;
  logic                  ea_valid;
  event_kind_t           ea_kind;
  logic                  eb_valid;
  event_kind_t           eb_kind;
  logic                  cnt_we;
  logic [7:0]            cnt_new;
  logic                  presc_we;
  logic [7:0]            presc_new;
  logic                  new_valid;
  logic                  step_ok;
  logic                  flush_done;

  // button select and scan length
  assign sel     = idx[SelW-1:0];
  assign bit_sel = idx[IndexWidth-1:0];
  assign idx_inc = idx + CountWidth'(1);
  assign n_lim   = (cfg.button_count > CountWidth'(ScanDepth)) ?
                   CountWidth'(ScanDepth) : cfg.button_count;

  // per-button evaluation
  always_comb begin
    c         = counts[sel];
    pressed   = (levels[bit_sel] == cfg.active_levels[bit_sel]);
    ea_valid  = 1'b0;
    ea_kind   = EV_DOWN;
    eb_valid  = 1'b0;
    eb_kind   = EV_UP;
    cnt_we    = 1'b0;
    cnt_new   = c;
    presc_we  = 1'b0;
    presc_new = prescaler;
    if (!pressed) begin
      if (c != 8'd0) begin
        if ((c >= cfg.short_min) && (c < cfg.keep_min)) begin
          ea_valid = 1'b1;
          ea_kind  = (c >= cfg.long_min) ? EV_LONG : EV_SHORT;
        end
        eb_valid = 1'b1;
        eb_kind  = EV_UP;
        cnt_we   = 1'b1;
        cnt_new  = 8'd0;
      end
    end else begin
      if (c == 8'd0) begin
        ea_valid = 1'b1;
        ea_kind  = EV_DOWN;
      end
      if (c > cfg.keep_min) begin
        if (c >= cfg.keep_max) begin
          cnt_we  = 1'b1;
          cnt_new = cfg.keep_min;
        end else begin
          presc_we = 1'b1;
          if (prescaler >= cfg.keep_prescale) begin
            eb_valid  = 1'b1;
            eb_kind   = EV_KEEP;
            cnt_we    = 1'b1;
            cnt_new   = c + 8'd1;
            presc_new = 8'd0;
          end else begin
            presc_new = prescaler + 8'd1;
          end
        end
      end else begin
        cnt_we  = 1'b1;
        cnt_new = c + 8'd1;
      end
    end
  end

  // a new event displaces the held one, which needs room downstream
  assign new_valid  = ((state == SC_EVAL) && ea_valid) ||
                      ((state == SC_SECOND) && evb_valid);
  assign step_ok    = !(new_valid && pend_valid && evq_full);
  assign flush_done = !pend_valid || !evq_full;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      SC_IDLE: begin
        if (job_valid && (n_lim != '0)) begin
          state_next = SC_EVAL;
        end
      end
      SC_EVAL: begin
        if (step_ok) begin
          state_next = SC_SECOND;
        end
      end
      SC_SECOND: begin
        if (step_ok) begin
          state_next = (idx_inc == n_btn) ? SC_FLUSH : SC_EVAL;
        end
      end
      SC_FLUSH: begin
        if (flush_done) begin
          state_next = SC_IDLE;
        end
      end
      default: begin
        state_next = SC_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    job_pop        = 1'b0;
    evq_push.valid = 1'b0;
    evq_push.ev    = pend;
    case (state)
      SC_IDLE: begin
        job_pop = job_valid;
      end
      SC_EVAL, SC_SECOND: begin
        evq_push.valid = new_valid && pend_valid && !evq_full;
      end
      SC_FLUSH: begin
        evq_push.valid   = pend_valid && !evq_full;
        evq_push.ev.last = 1'b1;
      end
      default: begin
        job_pop = 1'b0;
      end
    endcase
  end

  // walk registers, counters and prescaler
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SC_IDLE;
      idx        <= '0;
      n_btn      <= '0;
      prescaler  <= '0;
      pend_valid <= 1'b0;
      evb_valid  <= 1'b0;
      for (int i = 0; i < ScanDepth; i++) begin
        counts[i] <= '0;
      end
    end else begin
      state <= state_next;
      case (state)
        SC_IDLE: begin
          if (job_valid) begin
            levels <= job_levels;
            n_btn  <= n_lim;
            idx    <= '0;
          end
        end
        SC_EVAL: begin
          if (step_ok) begin
            if (cnt_we) begin
              counts[sel] <= cnt_new;
            end
            if (presc_we) begin
              prescaler <= presc_new;
            end
            evb_valid <= eb_valid;
            evb_kind  <= eb_kind;
            if (ea_valid) begin
              pend_valid <= 1'b1;
              pend       <= '{button_index: bit_sel, kind: ea_kind, last: 1'b0};
            end
          end
        end
        SC_SECOND: begin
          if (step_ok) begin
            idx <= idx_inc;
            if (evb_valid) begin
              pend_valid <= 1'b1;
              pend       <= '{button_index: bit_sel, kind: evb_kind, last: 1'b0};
            end
          end
        end
        SC_FLUSH: begin
          if (flush_done) begin
            pend_valid <= 1'b0;
          end
        end
        default: begin
          pend_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ rtl/bped_evq.sv @@
// ----------------------------------------------------------------------------
// bped_evq
// Result queue holding issued events until the receiver takes them.
// ----------------------------------------------------------------------------
module bped_evq (
  input  logic                  clk,
  input  logic                  rst,
  input  bped_pkg::event_push_t evq_push,
  output logic                  evq_full,
  output logic                  empty,
  input  logic                  pop,
  output bped_pkg::event_t      head
);
  import bped_pkg::*;

  localparam int PtrW = (EvqDepth > 1) ? $clog2(EvqDepth) : 1;
  localparam int CntW = $clog2(EvqDepth + 1);

  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            wr_en;
  logic            rd_en;
  event_t          mem [EvqDepth];

  assign wr_en    = evq_push.valid && !evq_full;
  assign rd_en    = pop && !empty;
  assign evq_full = (count == CntW'(EvqDepth));
  assign empty    = (count == '0);
  assign head     = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= evq_push.ev;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CntW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

@@ rtl/button_press_event_detector.sv @@
// ----------------------------------------------------------------------------
// button_press_event_detector
// Multi-button short/long/hold press detector with queue-style channels.
// ----------------------------------------------------------------------------
// Usage:
//   Ticks enter through push/full; a tick transfers when push is high and
//   full is low. Events leave through empty/pop; the oldest event sits on
//   button_index/event_kind/last_of_tick while empty is low and transfers
//   when pop is high. last_of_tick marks the final event of a scanning tick.
//   Registers are written through cfg_write/cfg_index/cfg_data, by the user
//   only while the block is idle; the block itself does not enforce it.
//   Ticks that do not start a scan only advance the divider. A scanning tick
//   is queued (two deep) and walked in an EVAL and a SECOND state per
//   button, after an IDLE state that takes the job and before a FLUSH state
//   that releases the final event. The button walk is the throughput limit.
//   The first event of a scan passes the job queue, the walk, the holding
//   register and the result queue to the ports. Each event is held until
//   another one or the end of the walk, so the last one can be marked.
//   A 16-entry result queue decouples the receiver; when it fills, the walk
//   stalls, then the job queue fills and full rises. Nothing is dropped.
//   Reset (rst, synchronous) restores register defaults, clears counters,
//   prescaler, divider and both queues; no clearing pass is needed.
// ----------------------------------------------------------------------------
module button_press_event_detector #(
  parameter int MAX_BUTTONS = bped_pkg::MaxButtonsDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [bped_pkg::LevelWidth-1:0]    button_levels,
  output logic                               empty,
  input  logic                               pop,
  output logic [bped_pkg::IndexWidth-1:0]    button_index,
  output logic [2:0]                         event_kind,
  output logic                               last_of_tick,
  input  logic                               cfg_write,
  input  logic [bped_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [bped_pkg::CfgDataWidth-1:0]  cfg_data
);
  import bped_pkg::*;

  cfg_t                  cfg;
  logic                  job_valid;
  logic [LevelWidth-1:0] job_levels;
  logic                  job_pop;
  event_push_t           evq_push;
  logic                  evq_full;
  event_t                head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CfgReset;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_BUTTON_COUNT:  cfg.button_count  <= cfg_data[CountWidth-1:0];
        CFG_ACTIVE_LEVELS: cfg.active_levels <= cfg_data;
        CFG_TICK_INTERVAL: cfg.tick_interval <= cfg_data;
        CFG_SHORT_MIN:     cfg.short_min     <= cfg_data;
        CFG_LONG_MIN:      cfg.long_min      <= cfg_data;
        CFG_KEEP_MIN:      cfg.keep_min      <= cfg_data;
        CFG_KEEP_MAX:      cfg.keep_max      <= cfg_data;
        CFG_KEEP_PRESCALE: cfg.keep_prescale <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // tick intake
  bped_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .button_levels (button_levels),
    .tick_interval (cfg.tick_interval),
    .job_valid     (job_valid),
    .job_levels    (job_levels),
    .job_pop       (job_pop)
  );

  // button walk
  bped_scan #(
    .MAX_BUTTONS (MAX_BUTTONS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .job_valid  (job_valid),
    .job_levels (job_levels),
    .job_pop    (job_pop),
    .evq_push   (evq_push),
    .evq_full   (evq_full)
  );

  // result queue
  bped_evq u_evq (
    .clk      (clk),
    .rst      (rst),
    .evq_push (evq_push),
    .evq_full (evq_full),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign button_index = head.button_index;
  assign event_kind   = head.kind;
  assign last_of_tick = head.last;

endmodule

@@ rtl/bped_checker.sv @@
// ----------------------------------------------------------------------------
// bped_checker
// Port-level checks on the detector, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bped_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            push,
  input logic                            full,
  input logic                            empty,
  input logic                            pop,
  input logic [bped_pkg::IndexWidth-1:0] button_index,
  input logic [2:0]                      event_kind,
  input logic                            last_of_tick
);
  import bped_pkg::*;

  // reset leaves both channels clear
  `ASSERT_AFTER_RESET(a_reset_empty, clk, rst, empty && !full)

  // waiting result holds until it transfers
  `ASSERT_NEXT(a_head_hold, clk, rst, !empty && !pop, !empty && $stable(button_index) && $stable(event_kind) && $stable(last_of_tick))

  // short and long events are never the last of a tick, as an up event follows
  `ASSERT_IMPLY(a_press_not_last, clk, rst, !empty && (event_kind == EV_SHORT || event_kind == EV_LONG), !last_of_tick)

  // after a short or long transfer the queue is empty or shows the same button's up
  `ASSERT_NEXT(a_up_follows, clk, rst, !empty && pop && (event_kind == EV_SHORT || event_kind == EV_LONG), empty || (event_kind == EV_UP && button_index == $past(button_index)))

endmodule

bind button_press_event_detector bped_checker u_checker (.*);

@@ verif/bped_event_checker.sv @@
// ----------------------------------------------------------------------------
// bped_event_checker
// Watches the tick, event and register channels of the button press event
// detector, keeps its own copy of the press counters, shared prescaler and
// tick divider, predicts the events of every accepted tick and compares each
// event transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module bped_event_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  logic                               full,
  input  logic [bped_pkg::LevelWidth-1:0]    button_levels,
  input  logic                               empty,
  input  logic                               pop,
  input  logic [bped_pkg::IndexWidth-1:0]    button_index,
  input  logic [2:0]                         event_kind,
  input  logic                               last_of_tick,
  input  logic                               cfg_write,
  input  logic [bped_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [bped_pkg::CfgDataWidth-1:0]  cfg_data,
  output int                                 mismatch_count,
  output int                                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import bped_pkg::*;

  // mirrored registers and detector state
  cfg_t       regs;
  logic [7:0] press_count [MaxButtonsDefault];
  logic [7:0] keep_prescaler;
  logic [7:0] tick_divider;
  event_t     expected_events [$];
  int         errors = 0;

  function automatic event_t make_event(input int idx, input event_kind_t kind);
    make_event = '{button_index: IndexWidth'(idx), kind: kind, last: 1'b0};
  endfunction

  // one tick: advance the divider and, on a scan, walk the buttons in order
  task automatic predict_tick_events(input logic [LevelWidth-1:0] levels);
    int         scanned;
    int         first;
    logic [7:0] c;
    logic       pressed;
    tick_divider = tick_divider + 8'd1;
    if (tick_divider >= regs.tick_interval) begin
      tick_divider = '0;
      first = expected_events.size();
      // counts past the button limit saturate
      scanned = regs.button_count;
      if (scanned > MaxButtonsDefault) scanned = MaxButtonsDefault;
      if (scanned > LevelWidth) scanned = LevelWidth;
      for (int i = 0; i < scanned; i++) begin
        pressed = (levels[i] == regs.active_levels[i]);
        c = press_count[i];
        if (!pressed) begin
          // release: classify the press, then report the key going up
          if (c != 8'd0) begin
            if (c >= regs.short_min && c < regs.keep_min) begin
              expected_events.push_back(
                make_event(i, (c >= regs.long_min) ? EV_LONG : EV_SHORT));
            end
            expected_events.push_back(make_event(i, EV_UP));
            press_count[i] = 8'd0;
          end
        end else begin
          if (c == 8'd0) expected_events.push_back(make_event(i, EV_DOWN));
          if (c > regs.keep_min) begin
            // hold repeat, paced by the prescaler all buttons share
            if (c >= regs.keep_max) begin
              press_count[i] = regs.keep_min;
            end else if (keep_prescaler >= regs.keep_prescale) begin
              expected_events.push_back(make_event(i, EV_KEEP));
              press_count[i] = c + 8'd1;
              keep_prescaler = 8'd0;
            end else begin
              keep_prescaler = keep_prescaler + 8'd1;
            end
          end else begin
            press_count[i] = c + 8'd1;
          end
        end
      end
      if (expected_events.size() > first) begin
        expected_events[expected_events.size()-1].last = 1'b1;
      end
    end
  endtask

  // register writes, tick transfers and event transfers
  always @(posedge clk) begin : monitor
    event_t want;
    if (rst) begin
      regs = CfgReset;
      foreach (press_count[i]) press_count[i] = 8'd0;
      keep_prescaler = 8'd0;
      tick_divider = 8'd0;
      expected_events.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          CFG_BUTTON_COUNT:  regs.button_count  = cfg_data[CountWidth-1:0];
          CFG_ACTIVE_LEVELS: regs.active_levels = cfg_data;
          CFG_TICK_INTERVAL: regs.tick_interval = cfg_data;
          CFG_SHORT_MIN:     regs.short_min     = cfg_data;
          CFG_LONG_MIN:      regs.long_min      = cfg_data;
          CFG_KEEP_MIN:      regs.keep_min      = cfg_data;
          CFG_KEEP_MAX:      regs.keep_max      = cfg_data;
          CFG_KEEP_PRESCALE: regs.keep_prescale = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) predict_tick_events(button_levels);
      if (pop && !empty) begin
        if (expected_events.size() == 0) begin
          $error("event transfer with none expected: button_index %0d event_kind %0d",
                 button_index, event_kind);
          errors++;
        end else begin
          want = expected_events.pop_front();
          if (button_index !== want.button_index) begin
            $error("button_index: expected %0d, actual %0d", want.button_index, button_index);
            errors++;
          end
          if (event_kind !== want.kind) begin
            $error("event_kind: expected %0d, actual %0d", want.kind, event_kind);
            errors++;
          end
          if (last_of_tick !== want.last) begin
            $error("last_of_tick: expected %0d, actual %0d", want.last, last_of_tick);
            errors++;
          end
        end
      end
    end
    mismatch_count <= errors;
    pending_count  <= expected_events.size();
  end

endmodule

@@ verif/tb_button_press_event_detector.sv @@
// ----------------------------------------------------------------------------
// tb_button_press_event_detector
// Drives ticks of button levels and register settings into the detector and
// drains its events under random idling and backpressure. A directed run
// covers down, up, short, long and keep events and hold wrap; random runs
// use well-formed press sequences with some noise across several settings,
// including a zero interval and saturated button counts. Checking is done
// by bped_event_checker.
// ----------------------------------------------------------------------------
module tb_button_press_event_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import bped_pkg::*;

  localparam int ResetCycles   = 11;
  localparam int SettleCycles  = 60;
  localparam int HoldCycles    = 500;
  localparam int WatchdogLimit = 4000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     push = 1'b0;
  logic                     full;
  logic [LevelWidth-1:0]    button_levels = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic [IndexWidth-1:0]    button_index;
  logic [2:0]               event_kind;
  logic                     last_of_tick;
  logic                     cfg_write = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0]  cfg_data = '0;

  int         mismatch_count;
  int         pending_count;
  int         sender_idle_pct = 0;
  int         receiver_idle_pct = 0;
  int         hold_requests = 0;
  int         holds_served = 0;
  int         hold_left = 0;
  int         quiet_cycles = 0;
  logic [7:0] pressed_mask = '0;
  logic [7:0] active_mask = '0;

  always #1 clk = ~clk;

  button_press_event_detector i_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .button_levels(button_levels),
    .empty        (empty),
    .pop          (pop),
    .button_index (button_index),
    .event_kind   (event_kind),
    .last_of_tick (last_of_tick),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  bped_event_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .button_levels (button_levels),
    .empty         (empty),
    .pop           (pop),
    .button_index  (button_index),
    .event_kind    (event_kind),
    .last_of_tick  (last_of_tick),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  // event receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left <= HoldCycles;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_reg(input cfg_reg_t idx, input logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // write every register while the detector is idle
  task automatic configure(input logic [7:0] count, input logic [7:0] active,
                           input logic [7:0] interval, input logic [7:0] short_min,
                           input logic [7:0] long_min, input logic [7:0] keep_min,
                           input logic [7:0] keep_max, input logic [7:0] prescale);
    set_reg(CFG_BUTTON_COUNT, count);
    set_reg(CFG_ACTIVE_LEVELS, active);
    set_reg(CFG_TICK_INTERVAL, interval);
    set_reg(CFG_SHORT_MIN, short_min);
    set_reg(CFG_LONG_MIN, long_min);
    set_reg(CFG_KEEP_MIN, keep_min);
    set_reg(CFG_KEEP_MAX, keep_max);
    set_reg(CFG_KEEP_PRESCALE, prescale);
    cfg_write <= 1'b0;
    @(posedge clk);
    active_mask = active;
  endtask

  // one tick transfer, after a random gap; without a gap push stays high between ticks
  task automatic send_tick(input logic [7:0] levels);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    button_levels <= levels;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // press sequences: each button toggles now and then, with some noise ticks
  task automatic send_presses(input int num, input int flip_pct, input int noise_pct);
    for (int n = 0; n < num; n++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        pressed_mask = 8'($urandom);
      end else begin
        for (int b = 0; b < 8; b++) begin
          if ($urandom_range(0, 99) < flip_pct) pressed_mask[b] = ~pressed_mask[b];
        end
      end
      send_tick(~(pressed_mask ^ active_mask));
    end
  endtask

  // stop offering ticks, wait for every expected event, let the walk finish
  task automatic quiesce();
    push <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    sender_idle_pct = 10;
    receiver_idle_pct <= 74;

    // reset settings: no buttons in use, ticks only advance the divider
    repeat (3) send_tick(8'($urandom));
    quiesce();

    // directed press shapes on all eight buttons
    configure(8, 8'hFF, 1, 2, 4, 6, 9, 0);
    send_tick(8'hFF);             // down everywhere
    send_tick(8'h00);             // too brief: up only
    repeat (2) send_tick(8'hFF);
    send_tick(8'h00);             // short then up
    repeat (4) send_tick(8'hFF);
    send_tick(8'h00);             // long then up
    repeat (10) send_tick(8'hFF); // keep repeats, counter returns to keep_min
    send_tick(8'h00);             // held past keep_min: up only
    send_tick(8'h5A);
    send_tick(8'hA5);
    quiesce();

    // small thresholds so every event kind shows up often
    configure(8, 8'($urandom), 1, 1, 3, 5, 8, 2);
    send_presses(40, 20, 10);
    quiesce();

    // saturated button count, zero interval, every threshold at zero
    configure(8'hFF, 8'h00, 0, 0, 0, 0, 0, 0);
    send_presses(25, 25, 10);
    quiesce();

    sender_idle_pct = 74;
    receiver_idle_pct <= 10;

    // three buttons, long out of reach, widest prescaler
    configure(3, 8'($urandom), 2, 2, 255, 4, 255, 255);
    send_presses(30, 20, 10);
    quiesce();

    // receiver holds off while ticks keep coming, so the detector fills up
    configure(8, 8'($urandom), 1, 1, 2, 3, 6, 0);
    hold_requests <= hold_requests + 1;
    send_presses(45, 30, 10);
    quiesce();

    sender_idle_pct = 0;
    receiver_idle_pct <= 0;

    configure(5, 8'($urandom), 3, 8'($urandom_range(0, 3)), 8'($urandom_range(2, 6)),
              8'($urandom_range(4, 10)), 8'($urandom_range(8, 14)),
              8'($urandom_range(0, 3)));
    send_presses(30, 20, 15);
    quiesce();

    configure(8, 8'($urandom), 1, 8'($urandom_range(0, 3)), 8'($urandom_range(1, 5)),
              8'($urandom_range(3, 8)), 8'($urandom_range(5, 12)),
              8'($urandom_range(0, 4)));
    send_presses(30, 20, 10);
    quiesce();

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bped_pkg.sv
rtl/bped_front.sv
rtl/bped_scan.sv
rtl/bped_evq.sv
rtl/button_press_event_detector.sv
rtl/bped_checker.sv
verif/bped_event_checker.sv
verif/tb_button_press_event_detector.sv
